### hdl/stl_pkg.sv
// stl_pkg: shared types and constants for the sound triggered night lamp
// holds opcode codes, register indexes and the transfer payload structs
// no dependencies
`timescale 1ns / 1ps

package stl_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 14;
    localparam int LUX_W    = 17;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    // item kinds
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LUX    = 2'd1,
        OP_TICK   = 2'd2,
        OP_BUTTON = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LUX_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_PERIOD     = 1'd1;

    // register reset values
    localparam logic [LUX_W-1:0]    LUX_THRESHOLD_RST = 17'd30;
    localparam logic [PERIOD_W-1:0] ON_PERIOD_RST     = 16'd600;

    // input transfer payload
    typedef struct packed {
        opcode_t              opcode;
        logic [SAMPLE_W-1:0]  sample;
        logic [LUX_W-1:0]     lux_value;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic lamp_on;
        logic sound_detected;
        logic night_mode;
    } out_item_t;

endpackage

### hdl/stl_in_stage.sv
// stl_in_stage: input register of the lamp pipeline
// splits each microphone sample into quotient and remainder by the block length
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_in_stage #(
    parameter int SAMPLES_PER_BLOCK = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  stl_pkg::in_item_t                   s_data,
    input  logic                                out_free,
    output logic                                item_valid,
    output stl_pkg::in_item_t                   item,
    output logic [stl_pkg::SAMPLE_W-1:0]        item_q,
    output logic [((SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1)-1:0] item_r
);

    localparam int RW         = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam int SW         = stl_pkg::SAMPLE_W;
    localparam int DIV_SHIFT  = SW + $clog2(SAMPLES_PER_BLOCK);
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + SAMPLES_PER_BLOCK - 1) / SAMPLES_PER_BLOCK;
    localparam int PROD_W     = 2 * SW + 2;

    logic                  item_valid_reg;
    stl_pkg::in_item_t     item_reg;
    logic [SW-1:0]         q_reg;
    logic [RW-1:0]         r_reg;

    logic [PROD_W-1:0]     prod;
    logic [SW-1:0]         div_q;
    logic [SW-1:0]         div_qd;
    logic [RW-1:0]         div_r;

    // sample divided by block length through a reciprocal multiply
    assign prod   = PROD_W'(s_data.sample) * PROD_W'(DIV_MULT);
    assign div_q  = SW'(prod >> DIV_SHIFT);
    assign div_qd = SW'(div_q * SW'(SAMPLES_PER_BLOCK));
    assign div_r  = RW'(s_data.sample - div_qd);

    assign s_ready = !item_valid_reg || out_free;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
            q_reg    <= div_q;
            r_reg    <= div_r;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign item_q     = q_reg;
    assign item_r     = r_reg;

endmodule

### hdl/stl_sound_window.sv
// stl_sound_window: block averaging and rise detection over a sliding window
// keeps the running block average as quotient plus remainder, no divider needed
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_sound_window #(
    parameter int SAMPLES_PER_BLOCK = 100,
    parameter int WINDOW_BLOCKS     = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                sample_en,
    input  logic [stl_pkg::SAMPLE_W-1:0]        sample_q,
    input  logic [((SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1)-1:0] sample_r,
    output logic                                sound_rise
);

    localparam int RW       = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam int SW       = stl_pkg::SAMPLE_W;
    localparam int CW       = SW + 4;
    localparam int FILL_W   = $clog2(WINDOW_BLOCKS + 1);
    localparam logic [RW:0]       DIV_VAL  = (RW + 1)'(SAMPLES_PER_BLOCK);
    localparam logic [RW-1:0]     CNT_LAST = RW'(SAMPLES_PER_BLOCK - 1);
    localparam logic [FILL_W-1:0] FILL_END = FILL_W'(WINDOW_BLOCKS);

    logic [RW-1:0]      cnt_reg;
    logic [SW-1:0]      acc_q_reg;
    logic [RW-1:0]      acc_r_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [SW-1:0]      win_reg [WINDOW_BLOCKS];

    logic [RW:0]        r_sum;
    logic               carry;
    logic [RW-1:0]      r_new;
    logic [SW-1:0]      q_new;
    logic               block_end;
    logic               filling;
    logic [CW-1:0]      new_x10;
    logic [WINDOW_BLOCKS-1:0] rise_vec;

    // running quotient and remainder of the block sum
    assign r_sum = {1'b0, acc_r_reg} + {1'b0, sample_r};
    assign carry = (r_sum >= DIV_VAL);
    assign r_new = carry ? RW'(r_sum - DIV_VAL) : RW'(r_sum);
    assign q_new = acc_q_reg + sample_q + SW'(carry);

    assign block_end = (cnt_reg == CNT_LAST);
    assign filling   = (fill_reg < FILL_END);

    // rise when the new average tops 110 percent of any window entry
    assign new_x10 = {1'b0, q_new, 3'b000} + {3'b000, q_new, 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_BLOCKS; gi++) begin : g_cmp
            logic [CW-1:0] old_x11;
            assign old_x11 = {1'b0, win_reg[gi], 3'b000} + {3'b000, win_reg[gi], 1'b0}
                           + {4'b0000, win_reg[gi]};
            assign rise_vec[gi] = (new_x10 > old_x11);
        end
    endgenerate

    assign sound_rise = sample_en && block_end && !filling && (|rise_vec);

    // block counters and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
            fill_reg  <= '0;
        end else if (sample_en) begin
            if (block_end) begin
                cnt_reg   <= '0;
                acc_q_reg <= '0;
                acc_r_reg <= '0;
                if (filling) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end else begin
                cnt_reg   <= cnt_reg + RW'(1);
                acc_q_reg <= q_new;
                acc_r_reg <= r_new;
            end
        end
    end

    // window shift line, oldest out and newest average in
    always_ff @(posedge aclk) begin
        if (sample_en && block_end) begin
            for (int i = 0; i < WINDOW_BLOCKS - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WINDOW_BLOCKS - 1] <= q_new;
        end
    end

endmodule

### hdl/stl_lamp_ctrl.sv
// stl_lamp_ctrl: configuration registers, night and lamp control, result register
// applies one item per cycle to the flags if out_free; drives the result transfer
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_lamp_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [stl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                item_valid,
    input  stl_pkg::in_item_t                   item,
    input  logic                                sound_rise,
    output logic                                out_free,
    output logic                                m_valid,
    input  logic                                m_ready,
    output stl_pkg::out_item_t                  m_data
);

    logic [stl_pkg::LUX_W-1:0]    lux_thr_reg;
    logic [stl_pkg::PERIOD_W-1:0] period_reg;

    logic                         sound_reg, sound_next;
    logic                         night_reg, night_next;
    logic                         lamp_reg, lamp_next;
    logic                         first_lux_reg, first_lux_next;
    logic [stl_pkg::PERIOD_W-1:0] lit_reg, lit_next;

    logic                         m_valid_reg;
    stl_pkg::out_item_t           m_data_reg;
    logic                         advance;
    logic                         dark;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = item_valid && out_free;
    assign dark     = (item.lux_value < lux_thr_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lux_thr_reg <= stl_pkg::LUX_THRESHOLD_RST;
            period_reg  <= stl_pkg::ON_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                stl_pkg::REG_LUX_THRESHOLD: lux_thr_reg <= cfg_wdata;
                stl_pkg::REG_ON_PERIOD:     period_reg  <= cfg_wdata[stl_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // flag update for the item at the head of the pipe
    always_comb begin
        sound_next     = sound_reg;
        night_next     = night_reg;
        lamp_next      = lamp_reg;
        first_lux_next = first_lux_reg;
        lit_next       = lit_reg;
        case (item.opcode)
            stl_pkg::OP_SAMPLE: begin
                if (sound_rise) begin
                    sound_next = 1'b1;
                end
            end
            stl_pkg::OP_LUX: begin
                first_lux_next = 1'b0;
                night_next     = first_lux_reg ? dark : (dark && sound_reg);
            end
            stl_pkg::OP_TICK: begin
                if (night_reg) begin
                    if (lit_reg < period_reg) begin
                        lamp_next = 1'b1;
                        lit_next  = lit_reg + stl_pkg::PERIOD_W'(1);
                    end else begin
                        lamp_next  = 1'b0;
                        sound_next = 1'b0;
                        night_next = 1'b0;
                        lit_next   = '0;
                    end
                end
            end
            default: begin
                night_next = 1'b1;
                lit_next   = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_reg     <= 1'b0;
            night_reg     <= 1'b0;
            lamp_reg      <= 1'b0;
            first_lux_reg <= 1'b1;
            lit_reg       <= '0;
        end else if (advance) begin
            sound_reg     <= sound_next;
            night_reg     <= night_next;
            lamp_reg      <= lamp_next;
            first_lux_reg <= first_lux_next;
            lit_reg       <= lit_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.lamp_on        <= lamp_next;
            m_data_reg.sound_detected <= sound_next;
            m_data_reg.night_mode     <= night_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/sound_triggered_night_lamp.sv
// sound_triggered_night_lamp: top level of the sound triggered night lamp
// depends on stl_pkg, stl_in_stage, stl_sound_window, stl_lamp_ctrl
//
//   port group | direction | handshake         | payload
//   s_         | in        | s_valid / s_ready | stl_pkg::in_item_t  (opcode, sample, lux_value)
//   m_         | out       | m_valid / m_ready | stl_pkg::out_item_t (lamp_on, sound_detected,
//              |           |                   |                      night_mode)
//   cfg_       | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// one item per cycle while no result is held back; each result follows its input transfer
// through the input register, then the flag update into the result register
// the sample divide sits before the input register; block sum compare sits before the result
// reset is synchronous and active low; it clears all flags, counters and handshake state
// a held result stalls the input stage only while both registers are full
`timescale 1ns / 1ps

module sound_triggered_night_lamp #(
    parameter int SAMPLES_PER_BLOCK = 100,
    parameter int WINDOW_BLOCKS     = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [stl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  stl_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output stl_pkg::out_item_t              m_data
);

    localparam int RW = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;

    logic                          out_free;
    logic                          item_valid;
    stl_pkg::in_item_t             item;
    logic [stl_pkg::SAMPLE_W-1:0]  item_q;
    logic [RW-1:0]                 item_r;
    logic                          sample_en;
    logic                          sound_rise;

    // input register with sample split
    stl_in_stage #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_free   (out_free),
        .item_valid (item_valid),
        .item       (item),
        .item_q     (item_q),
        .item_r     (item_r)
    );

    // sample transfer moves on to the window only when it advances
    assign sample_en = item_valid && out_free && (item.opcode == stl_pkg::OP_SAMPLE);

    stl_sound_window #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .WINDOW_BLOCKS     (WINDOW_BLOCKS)
    ) u_sound_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sample_en  (sample_en),
        .sample_q   (item_q),
        .sample_r   (item_r),
        .sound_rise (sound_rise)
    );

    stl_lamp_ctrl u_lamp_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .sound_rise (sound_rise),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for the sound triggered night lamp
// depends on stl_pkg and sound_triggered_night_lamp; drives items, checks each result
// against an in-bench prediction of the block-average window, lux and lamp timer logic
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLES_PER_BLOCK = 100;
    localparam int WINDOW_BLOCKS     = 5;
    localparam int SAMPLE_W          = stl_pkg::SAMPLE_W;
    localparam int LUX_W             = stl_pkg::LUX_W;
    localparam int PERIOD_W          = stl_pkg::PERIOD_W;
    localparam int CFG_W             = stl_pkg::CFG_W;
    localparam int CFG_IDX_W         = stl_pkg::CFG_IDX_W;
    localparam int SUM_W             = 21;
    localparam int SAMPLE_MAX        = (1 << SAMPLE_W) - 1;
    localparam int LUX_MAX           = (1 << LUX_W) - 1;
    localparam int PERIOD_MAX        = (1 << PERIOD_W) - 1;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_TOGGLE,
        RDY_RARE
    } ready_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    stl_pkg::in_item_t    s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    stl_pkg::out_item_t   m_data;

    // predicted block state
    logic [LUX_W-1:0]    thr_q       = stl_pkg::LUX_THRESHOLD_RST;
    logic [PERIOD_W-1:0] period_q    = stl_pkg::ON_PERIOD_RST;
    logic                fill_active = 1'b1;
    int unsigned         blk_cnt     = 0;
    int unsigned         filled_cnt  = 0;
    logic [SUM_W-1:0]    blk_sum     = '0;
    logic [SUM_W-1:0]    avg_win [WINDOW_BLOCKS] = '{default: '0};
    logic                win_scaled  = 1'b0;
    logic                sound_q     = 1'b0;
    logic                night_q     = 1'b0;
    logic                lux_first   = 1'b1;
    logic                lamp_q      = 1'b0;
    logic [PERIOD_W-1:0] lit_cnt     = '0;

    stl_pkg::out_item_t lamp_expected_q[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          level      = 500;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_left = 0;

    sound_triggered_night_lamp #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .WINDOW_BLOCKS     (WINDOW_BLOCKS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("sound_triggered_night_lamp regression: fail");
        $finish;
    end

    // advance the predicted state by one item and return the lamp outputs
    function automatic stl_pkg::out_item_t step_lamp(input stl_pkg::in_item_t it);
        stl_pkg::out_item_t res;
        logic [SUM_W-1:0]   blk_avg;
        logic               rose;
        logic               dark;
        rose = 1'b0;
        dark = it.lux_value < thr_q;
        case (it.opcode)
            stl_pkg::OP_SAMPLE: begin
                blk_sum = blk_sum + it.sample;
                blk_cnt++;
                if (blk_cnt == SAMPLES_PER_BLOCK) begin
                    blk_cnt = 0;
                    if (fill_active) begin
                        // first blocks keep raw sums
                        if (filled_cnt < WINDOW_BLOCKS)
                            avg_win[filled_cnt] = blk_sum;
                        filled_cnt++;
                        if (filled_cnt >= WINDOW_BLOCKS)
                            fill_active = 1'b0;
                    end else begin
                        // raw sums turn into averages on the first compared block
                        if (!win_scaled) begin
                            foreach (avg_win[i])
                                avg_win[i] = SUM_W'(avg_win[i] / SAMPLES_PER_BLOCK);
                            win_scaled = 1'b1;
                        end
                        blk_avg = SUM_W'(blk_sum / SAMPLES_PER_BLOCK);
                        foreach (avg_win[i])
                            if (longint'(blk_avg) * 10 > longint'(avg_win[i]) * 11)
                                rose = 1'b1;
                        if (rose)
                            sound_q = 1'b1;
                        for (int i = 0; i < WINDOW_BLOCKS - 1; i++)
                            avg_win[i] = avg_win[i + 1];
                        avg_win[WINDOW_BLOCKS - 1] = blk_avg;
                    end
                    blk_sum = '0;
                end
            end
            stl_pkg::OP_LUX: begin
                if (lux_first) begin
                    night_q   = dark;
                    lux_first = 1'b0;
                end else begin
                    night_q = dark && sound_q;
                end
            end
            stl_pkg::OP_TICK: begin
                if (night_q) begin
                    if (lit_cnt < period_q) begin
                        lamp_q  = 1'b1;
                        lit_cnt = lit_cnt + 1'b1;
                    end else begin
                        lamp_q  = 1'b0;
                        sound_q = 1'b0;
                        night_q = 1'b0;
                        lit_cnt = '0;
                    end
                end
            end
            stl_pkg::OP_BUTTON: begin
                night_q = 1'b1;
                lit_cnt = '0;
            end
        endcase
        res.lamp_on        = lamp_q;
        res.sound_detected = sound_q;
        res.night_mode     = night_q;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        stl_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lamp_expected_q.size() == 0) begin
                $error("result transfer with nothing pending: %p", m_data);
                fail_count++;
            end else begin
                want = lamp_expected_q.pop_front();
                check_field("lamp_on", want.lamp_on, m_data.lamp_on);
                check_field("sound_detected", want.sound_detected, m_data.sound_detected);
                check_field("night_mode", want.night_mode, m_data.night_mode);
            end
        end
    end

    // receiver stall pattern, with the mode picked anew at random
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(8, 64);
        end
        ready_left--;
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_TOGGLE: m_ready <= ~m_ready;
            RDY_RARE:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // one input transfer, with bursty gaps
    task automatic send_item(input stl_pkg::opcode_t op, input int smp, input int lux);
        stl_pkg::in_item_t it;
        int                gap;
        it.opcode    = op;
        it.sample    = SAMPLE_W'(smp);
        it.lux_value = LUX_W'(lux);
        @(negedge aclk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        lamp_expected_q.push_back(step_lamp(it));
    endtask

    // samples in [lo, hi] until the current block closes
    task automatic send_block(input int lo, input int hi);
        do
            send_item(stl_pkg::OP_SAMPLE, $urandom_range(lo, hi), $urandom_range(0, LUX_MAX));
        while (blk_cnt != 0);
    endtask

    // drop valid and wait for every pending result
    task automatic wait_idle();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (lamp_expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            stl_pkg::REG_LUX_THRESHOLD: thr_q    = value[LUX_W-1:0];
            stl_pkg::REG_ON_PERIOD:     period_q = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] thr, input logic [31:0] period);
        write_reg(stl_pkg::REG_LUX_THRESHOLD, thr);
        write_reg(stl_pkg::REG_ON_PERIOD, period);
    endtask

    // field extremes, first lux reading, ticks with and without night, button
    task automatic test_directed_extremes();
        set_config(LUX_MAX, 2);
        send_item(stl_pkg::OP_SAMPLE, 0, LUX_MAX);
        send_item(stl_pkg::OP_SAMPLE, SAMPLE_MAX, 0);
        // tick while not night does nothing
        send_item(stl_pkg::OP_TICK, SAMPLE_MAX, LUX_MAX);
        // first reading sets night on darkness alone
        send_item(stl_pkg::OP_LUX, 0, LUX_MAX - 1);
        send_item(stl_pkg::OP_TICK, 0, 0);
        send_item(stl_pkg::OP_TICK, 0, 0);
        // period used up: everything clears
        send_item(stl_pkg::OP_TICK, SAMPLE_MAX, 0);
        send_item(stl_pkg::OP_TICK, 0, LUX_MAX);
        // later readings need the sound flag too
        send_item(stl_pkg::OP_LUX, SAMPLE_MAX, 0);
        send_item(stl_pkg::OP_LUX, 0, LUX_MAX);
        send_item(stl_pkg::OP_BUTTON, SAMPLE_MAX, LUX_MAX);
        send_item(stl_pkg::OP_TICK, 0, 0);
        // button restarts the count but keeps the lamp level
        send_item(stl_pkg::OP_BUTTON, 0, 0);
        repeat (3) send_item(stl_pkg::OP_TICK, 0, 0);
        wait_idle();
        // zero threshold and zero period
        set_config(0, 0);
        send_item(stl_pkg::OP_LUX, 0, 0);
        send_item(stl_pkg::OP_BUTTON, 0, 0);
        send_item(stl_pkg::OP_TICK, 0, 0);
        send_item(stl_pkg::OP_TICK, 0, 0);
        wait_idle();
    endtask

    // quiet blocks until the window is full
    task automatic test_first_fill();
        set_config(32'(stl_pkg::LUX_THRESHOLD_RST), 32'(stl_pkg::ON_PERIOD_RST));
        while (fill_active) send_block(0, 1500);
        wait_idle();
    endtask

    // loud block after a quiet window sets sound, lux then arms the lamp
    task automatic test_sound_trigger();
        set_config(1000, 5);
        send_block(15000, SAMPLE_MAX);
        send_item(stl_pkg::OP_LUX, 0, 999);
        send_item(stl_pkg::OP_LUX, 0, 1000);
        send_item(stl_pkg::OP_LUX, SAMPLE_MAX, 999);
        repeat (7) send_item(stl_pkg::OP_TICK, 0, 0);
        send_item(stl_pkg::OP_LUX, 0, 0);
        send_block(0, 1500);
        send_block(15000, SAMPLE_MAX);
        send_item(stl_pkg::OP_BUTTON, 0, 0);
        send_item(stl_pkg::OP_TICK, 0, 0);
        wait_idle();
    endtask

    // period lowered below the running tick count
    task automatic test_period_lowered();
        set_config(LUX_MAX, PERIOD_MAX);
        send_item(stl_pkg::OP_BUTTON, 0, 0);
        repeat (6) send_item(stl_pkg::OP_TICK, 0, 0);
        wait_idle();
        write_reg(stl_pkg::REG_ON_PERIOD, 3);
        send_item(stl_pkg::OP_TICK, 0, 0);
        send_item(stl_pkg::OP_TICK, 0, 0);
        wait_idle();
    endtask

    // mixed traffic with drifting sample level, new settings per phase
    task automatic test_random_traffic();
        int roll;
        int v;
        logic [31:0] thr;
        logic [31:0] period;
        repeat (4) begin
            case ($urandom_range(0, 3))
                0: thr = LUX_MAX;
                1: thr = $urandom_range(0, LUX_MAX);
                default: thr = $urandom_range(0, 2000);
            endcase
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PERIOD_MAX)
                                                : $urandom_range(0, 12);
            set_config(thr, period);
            repeat (140) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    if ($urandom_range(0, 79) == 0)
                        level = $urandom_range(0, SAMPLE_MAX);
                    if ($urandom_range(0, 49) == 0) begin
                        v = $urandom_range(0, SAMPLE_MAX);
                    end else begin
                        v = level + int'($urandom_range(0, 200)) - 100;
                        if (v < 0) v = 0;
                        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                    end
                    send_item(stl_pkg::OP_SAMPLE, v, $urandom_range(0, LUX_MAX));
                end else if (roll < 80) begin
                    case ($urandom_range(0, 3))
                        0: v = ($urandom_range(0, 1) == 0) ? 0 : LUX_MAX;
                        1: v = $urandom_range(0, LUX_MAX);
                        default: begin
                            v = int'(thr_q) + int'($urandom_range(0, 6)) - 3;
                            if (v < 0) v = 0;
                            if (v > LUX_MAX) v = LUX_MAX;
                        end
                    endcase
                    send_item(stl_pkg::OP_LUX, $urandom_range(0, SAMPLE_MAX), v);
                end else if (roll < 95) begin
                    send_item(stl_pkg::OP_TICK, $urandom_range(0, SAMPLE_MAX),
                              $urandom_range(0, LUX_MAX));
                end else begin
                    send_item(stl_pkg::OP_BUTTON, $urandom_range(0, SAMPLE_MAX),
                              $urandom_range(0, LUX_MAX));
                end
            end
            wait_idle();
        end
    endtask

    // main sequence
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_first_fill();
        test_sound_trigger();
        test_period_lowered();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("sound_triggered_night_lamp regression: pass");
        else
            $display("sound_triggered_night_lamp regression: fail");
        $finish;
    end

endmodule

### sim.f
hdl/stl_pkg.sv
hdl/stl_in_stage.sv
hdl/stl_sound_window.sv
hdl/stl_lamp_ctrl.sv
hdl/sound_triggered_night_lamp.sv
dv/tb_top.sv
